### sv/esc_pkg.sv
// esc_pkg: shared constants, types and calendar functions for the
// epoch seconds to calendar date block. no dependencies.
package esc_pkg;

  localparam int SECS_W  = 32;
  localparam int DAYS_W  = 16;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YLEN_W  = 9;

  // 86400 = 675 << 7; days = ((secs >> 7) * ceil(2^35 / 675)) >> 35, exact below 2^25
  localparam int DAY_SHIFT   = 7;
  localparam int QUOT_W      = SECS_W - DAY_SHIFT;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_W      = QUOT_W + RECIP_W;

  localparam logic [RECIP_W-1:0] DAY_RECIP    = RECIP_W'(50903317);
  localparam logic [YEAR_W-1:0]  FIRST_YEAR   = YEAR_W'(1970);
  localparam logic [1:0]         FIRST_MOD4   = 2'(1970 % 4);
  localparam logic [6:0]         FIRST_MOD100 = 7'(1970 % 100);
  localparam logic [8:0]         FIRST_MOD400 = 9'(1970 % 400);
  localparam logic [6:0]         LAST_MOD100  = 7'd99;
  localparam logic [8:0]         LAST_MOD400  = 9'd399;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic load;
    logic div_step;
    logic year_step;
    logic month_step;
  } esc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } esc_stat_t;

  function automatic logic [YLEN_W-1:0] year_len(input logic leap);
    return leap ? YLEN_W'(366) : YLEN_W'(365);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

### sv/esc_ctrl.sv
// esc_ctrl: sequencer for the date conversion
// depends on esc_pkg; drives esc_dpath by command struct
module esc_ctrl
  import esc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output esc_cmd_t  cmd,
  input  esc_stat_t stat
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_YEAR  = 5'b00100,
    ST_MONTH = 5'b01000,
    ST_DONE  = 5'b10000
  } esc_state_t;

  esc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_YEAR;
      end
      ST_YEAR: begin
        if (stat.year_done) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (stat.month_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

### sv/esc_dpath.sv
// esc_dpath: day division, year walk and month walk registers
// depends on esc_pkg; commanded by esc_ctrl
module esc_dpath
  import esc_pkg::*;
(
  input  logic               clk,
  input  logic [SECS_W-1:0]  secs,
  input  esc_cmd_t           cmd,
  output esc_stat_t          stat,
  output logic [YEAR_W-1:0]  year_q,
  output logic [MONTH_W-1:0] month_q,
  output logic [DAY_W-1:0]   day_q
);

  logic [QUOT_W-1:0]  secs_r;
  logic [DAYS_W-1:0]  days_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [1:0]         mod4_r;
  logic [6:0]         mod100_r;
  logic [8:0]         mod400_r;

  logic [PROD_W-1:0]  day_prod;
  logic               leap;
  logic [DAYS_W-1:0]  ylen;
  logic [DAYS_W-1:0]  mlen;

  assign day_prod = PROD_W'(secs_r) * PROD_W'(DAY_RECIP);

  assign leap = (mod400_r == '0) || ((mod4_r == '0) && (mod100_r != '0));
  assign ylen = DAYS_W'(year_len(leap));
  assign mlen = DAYS_W'(month_len(month_r, leap));

  assign stat.year_done  = (days_r < ylen);
  assign stat.month_done = (month_r == MONTH_DEC) || (days_r < mlen);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs_r   <= secs[SECS_W-1:DAY_SHIFT];
      days_r   <= '0;
      year_r   <= FIRST_YEAR;
      month_r  <= MONTH_JAN;
      mod4_r   <= FIRST_MOD4;
      mod100_r <= FIRST_MOD100;
      mod400_r <= FIRST_MOD400;
    end else if (cmd.div_step) begin
      days_r <= day_prod[PROD_W-1:RECIP_SHIFT];
    end else if (cmd.year_step) begin
      days_r   <= days_r - ylen;
      year_r   <= year_r + YEAR_W'(1);
      mod4_r   <= mod4_r + 2'd1;
      mod100_r <= (mod100_r == LAST_MOD100) ? 7'd0 : mod100_r + 7'd1;
      mod400_r <= (mod400_r == LAST_MOD400) ? 9'd0 : mod400_r + 9'd1;
    end else if (cmd.month_step) begin
      days_r  <= days_r - mlen;
      month_r <= month_r + MONTH_W'(1);
    end
  end

  assign year_q  = year_r;
  assign month_q = month_r;
  assign day_q   = days_r[DAY_W-1:0] + DAY_W'(1);

endmodule

### sv/epoch_seconds_to_calendar_date.sv
// epoch_seconds_to_calendar_date: top level of the epoch to date converter
// depends on esc_pkg, esc_ctrl and esc_dpath
//
// usage:
//   raise start with in_epoch_seconds while busy is low; the transfer happens
//   at that clock edge and busy goes high on the next cycle.
//   the date appears on out_year_number, out_month_number and
//   out_day_of_month for exactly one cycle with out_valid high; the receiver
//   cannot stall it, so it must take the result in that cycle.
//   from the input transfer the sequencer runs through ST_DIV, where the
//   reciprocal multiply does the divide by 86400, then ST_YEAR and ST_MONTH,
//   the year and month walks at one subtraction per cycle, and then ST_DONE.
//   busy drops the cycle after out_valid, so the next transfer can start then;
//   a new input is taken only once the last result has been delivered.
//   reset (rst_n low, synchronous) returns the sequencer to idle; no result
//   in flight is delivered.
module epoch_seconds_to_calendar_date
  import esc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [SECS_W-1:0]  in_epoch_seconds,
  output logic               out_valid,
  output logic [YEAR_W-1:0]  out_year_number,
  output logic [MONTH_W-1:0] out_month_number,
  output logic [DAY_W-1:0]   out_day_of_month
);

  esc_cmd_t  cmd;
  esc_stat_t stat;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  esc_dpath u_dpath (
    .clk     (clk),
    .secs    (in_epoch_seconds),
    .cmd     (cmd),
    .stat    (stat),
    .year_q  (out_year_number),
    .month_q (out_month_number),
    .day_q   (out_day_of_month)
  );

endmodule

### tb/tb_epoch_seconds_to_calendar_date.sv
`timescale 1ns / 1ps
// tb_epoch_seconds_to_calendar_date: self-checking bench for the epoch seconds
// to calendar date converter, with directed dates, then random bursts
// depends on esc_pkg and epoch_seconds_to_calendar_date
module tb_epoch_seconds_to_calendar_date
  import esc_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 900;
  localparam int MAX_DAY      = 49710;
  localparam longint unsigned DAY_SECS = 86400;
  localparam logic [SECS_W-1:0] LAST_SECS = '1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [SECS_W-1:0]  in_epoch_seconds;
  logic               out_valid;
  logic [YEAR_W-1:0]  out_year_number;
  logic [MONTH_W-1:0] out_month_number;
  logic [DAY_W-1:0]   out_day_of_month;

  cal_date_t expected_dates[$];
  int        bad_dates = 0;
  int        cycles = 0;

  epoch_seconds_to_calendar_date i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year_number  (out_year_number),
    .out_month_number (out_month_number),
    .out_day_of_month (out_day_of_month)
  );

  always #5 clk = ~clk;

  // walk whole years from the epoch, then months within the year reached
  function automatic cal_date_t calendar_of(input logic [SECS_W-1:0] secs);
    int unsigned days_left;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    bit          leap;
    cal_date_t   d;
    days_left = secs / DAY_SECS;
    yr = 1970;
    forever begin
      leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
      span = leap ? 366 : 365;
      if (days_left < span) break;
      days_left -= span;
      yr++;
    end
    mon = 1;
    forever begin
      case (MONTH_W'(mon))
        MONTH_FEB: span = leap ? 29 : 28;
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: span = 30;
        default: span = 31;
      endcase
      if (MONTH_W'(mon) == MONTH_DEC || days_left < span) break;
      days_left -= span;
      mon++;
    end
    d.year  = YEAR_W'(yr);
    d.month = MONTH_W'(mon);
    d.day   = DAY_W'(days_left + 1);
    return d;
  endfunction

  // start stays high after the transfer; pause lowers it
  task automatic send_seconds(input logic [SECS_W-1:0] secs);
    start <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    expected_dates.push_back(calendar_of(secs));
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic test_field_extremes();
    logic [SECS_W-1:0] picks [7] = '{
      32'd0, 32'd1, LAST_SECS, 32'h7fff_ffff, 32'h8000_0000,
      32'haaaa_aaaa, 32'h5555_5555
    };
    foreach (picks[i]) send_seconds(picks[i]);
    pause(3);
  endtask

  // time of day dropped, year and month rollovers
  task automatic test_day_edges();
    logic [SECS_W-1:0] picks [6] = '{
      32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
      32'd94694399, 32'd94694400
    };
    foreach (picks[i]) send_seconds(picks[i]);
    pause(1);
  endtask

  // leap day in 1972 and 2000, no leap day in 2100
  task automatic test_leap_rules();
    logic [SECS_W-1:0] picks [7] = '{
      32'd68169600, 32'd68256000, 32'd951782400, 32'd978220799,
      32'd4102444799, 32'd4107456000, 32'd4107542400
    };
    foreach (picks[i]) send_seconds(picks[i]);
    pause(7);
  endtask

  task automatic test_random_dates();
    int                sent;
    int                burst;
    longint unsigned   day_start;
    longint unsigned   pick;
    logic [SECS_W-1:0] secs;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        day_start = DAY_SECS * $urandom_range(0, MAX_DAY);
        case ($urandom_range(0, 3))
          0: secs = $urandom;
          1: secs = SECS_W'(day_start);
          2: secs = (day_start == 0) ? '0 : SECS_W'(day_start - 1);
          default: begin
            pick = day_start + $urandom_range(0, 86399);
            secs = (pick > LAST_SECS) ? LAST_SECS : SECS_W'(pick);
          end
        endcase
        send_seconds(secs);
        sent++;
      end
      pause($urandom_range(1, 120));
    end
  endtask

  always @(posedge clk) begin
    cal_date_t want;
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        bad_dates++;
        if (bad_dates <= 10)
          $display("unexpected date %0d-%0d-%0d", out_year_number,
                   out_month_number, out_day_of_month);
      end else begin
        want = expected_dates.pop_front();
        if (want.year !== out_year_number || want.month !== out_month_number ||
            want.day !== out_day_of_month) begin
          bad_dates++;
          if (bad_dates <= 10)
            $display("date mismatch: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                     want.year, want.month, want.day, out_year_number,
                     out_month_number, out_day_of_month);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_epoch_seconds <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_day_edges();
    test_leap_rules();
    test_random_dates();
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_dates == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
